// ----- sv/stepped_id_cursor_table_unit_defines.svh -----
// Assertion macros for the cursor table unit.
`ifndef STEPPED_ID_CURSOR_TABLE_UNIT_DEFINES_SVH
`define STEPPED_ID_CURSOR_TABLE_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SICT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SICT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SICT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SICT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/sict_pkg.sv -----
package sict_pkg;
  localparam int unsigned ValW = 64;
  localparam logic [1:0] FUNC_RESERVE    = 2'd0;
  localparam logic [1:0] FUNC_SEED       = 2'd1;
  localparam logic [1:0] FUNC_NOTE       = 2'd2;
  localparam logic [1:0] FUNC_INVALIDATE = 2'd3;
  localparam logic [1:0] ST_ISSUED = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_NONE   = 2'd2;
  localparam logic [ValW-1:0] ALL_ONES = {ValW{1'b1}};

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_READ  = 8'b00000010,
    S_PREP  = 8'b00000100,
    S_DIV   = 8'b00001000,
    S_ALIGN = 8'b00010000,
    S_MUL   = 8'b00100000,
    S_WRITE = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_t;
endpackage

// ----- sv/sict_ram.sv -----
module sict_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- sv/stepped_id_cursor_table_unit.sv -----
// Channel | Beat fields (low bit up)                                        | Dir
// in      | tdata: table_index[5:0], id_count, id_step, id_offset, given_value | in
//         | tuser: func[1:0]                                                 |
// out     | tdata: first_id[63:0]; tuser: status[1:0]                        | out
// out_tvalid rises after a seed or a reserve on a valid entry, once a restoring divider
// has found cur mod step and a shift-add multiplier has formed the span; an offset not
// below the step adds a divide pass first, and a step of one skips the divider. Notes and
// invalidates skip both. The cursor store is one RAM with a registered read.
// Reset clears all valid bits at once; the cursor RAM needs no clearing.
// A stalled result holds in the output register; input reopens the cycle after it is taken.
`include "stepped_id_cursor_table_unit_defines.svh"
module stepped_id_cursor_table_unit #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [263:0] in_tdata,  // table_index[5:0], id_count, id_step, id_offset, given
  input  logic [1:0]   in_tuser,  // func[1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata, // first_id[63:0]
  output logic [1:0]   out_tuser  // status[1:0]
);
  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam int unsigned W = sict_pkg::ValW;

  sict_pkg::state_t state_r, state_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [1:0]  func_r;
  logic [AW-1:0] idx_r;
  logic in_tab_r, was_valid_r;
  logic [W-1:0] cnt_r, step_r, off_r, given_r, cur_r;
  logic [W-1:0] rem_r, quo_r, acc_r, mcand_r, mplier_r;
  logic ovf_r;
  logic [6:0] bit_r;
  logic [W-1:0] first_r;
  logic obusy_r;
  logic [1:0] ostat_r;
  logic [W-1:0] ofirst_r;

  logic [5:0] in_idx;
  logic [W-1:0] rdata;
  logic we;
  logic [W-1:0] wdata;

  assign in_idx = in_tdata[5:0];
  assign in_tready = (state_r == sict_pkg::S_IDLE) && !obusy_r;
  assign out_tvalid = obusy_r;
  assign out_tdata = ofirst_r;
  assign out_tuser = ostat_r;

  sict_ram #(.WIDTH(W), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk(clk), .we(we), .waddr(idx_r), .wdata(wdata), .raddr(idx_r), .rdata(rdata)
  );

  // Cursor after create/seed/note, step-independent parts.
  logic [W-1:0] base;
  always_comb begin
    base = was_valid_r ? rdata : '0;
    if (func_r == sict_pkg::FUNC_SEED && base < given_r) begin
      base = given_r;
    end
    if (func_r == sict_pkg::FUNC_NOTE && base <= given_r) begin
      base = given_r + 1'b1;
    end
  end

  logic [W:0] trial;
  logic [W-1:0] offm, bump, pl, k;
  logic [W:0] sum1, sum2;
  logic [W:0] msum;
  always_comb begin
    trial = {rem_r, quo_r[W-1]} - {1'b0, step_r};
    offm = (off_r >= step_r) ? rem_r : off_r;
    bump = (offm > rem_r) ? (offm - rem_r) : (step_r - (rem_r - offm));
    sum1 = {1'b0, cur_r} + {1'b0, bump};
    msum = {1'b0, acc_r} + {1'b0, mcand_r};
    sum2 = {1'b0, first_r} + {1'b0, acc_r};
    k = cnt_r - 1'b1;
    if (cnt_r <= 1) begin
      pl = (first_r == sict_pkg::ALL_ONES) ? first_r : first_r + 1'b1;
    end else if (ovf_r || sum2[W]) begin
      pl = sict_pkg::ALL_ONES;
    end else begin
      pl = (sum2[W-1:0] == sict_pkg::ALL_ONES) ? sum2[W-1:0] : sum2[W-1:0] + 1'b1;
    end
  end

  // Offset reduction is an extra divide pass, run first, with the offset as dividend.
  logic off_pass_r;

  always_comb begin
    state_nxt = state_r;
    we = 1'b0;
    wdata = pl;
    case (state_r)
      sict_pkg::S_IDLE: if (in_tvalid && in_tready) state_nxt = sict_pkg::S_READ;
      sict_pkg::S_READ: state_nxt = sict_pkg::S_PREP;
      sict_pkg::S_PREP: state_nxt = sict_pkg::S_OUT;
      sict_pkg::S_DIV: if (bit_r == 7'd0) state_nxt = sict_pkg::S_ALIGN;
      sict_pkg::S_ALIGN: state_nxt = off_pass_r ? sict_pkg::S_DIV : sict_pkg::S_MUL;
      sict_pkg::S_MUL: if (bit_r == 7'd0) state_nxt = sict_pkg::S_WRITE;
      sict_pkg::S_WRITE: begin
        we = 1'b1;
        state_nxt = sict_pkg::S_OUT;
      end
      sict_pkg::S_OUT: state_nxt = sict_pkg::S_IDLE;
      default: state_nxt = sict_pkg::S_IDLE;
    endcase
    if (state_r == sict_pkg::S_PREP && func_r == sict_pkg::FUNC_NOTE && in_tab_r
        && given_r != sict_pkg::ALL_ONES) begin
      we = 1'b1;
      wdata = base;
    end
    if (state_r == sict_pkg::S_PREP && in_tab_r && (func_r == sict_pkg::FUNC_SEED ||
        (func_r == sict_pkg::FUNC_RESERVE && was_valid_r))) begin
      state_nxt = (step_r <= 1) ? sict_pkg::S_MUL : sict_pkg::S_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sict_pkg::S_IDLE;
      valid_r <= '0;
      obusy_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_tvalid && out_tready) obusy_r <= 1'b0;
      case (state_r)
        sict_pkg::S_IDLE: if (in_tvalid && in_tready) begin
          func_r <= in_tuser;
          idx_r <= AW'(in_idx);
          in_tab_r <= {26'd0, in_idx} < TABLE_ENTRIES;
          cnt_r <= (in_tdata[69:6] == '0) ? 64'd1 : in_tdata[69:6];
          step_r <= (in_tdata[133:70] == '0) ? 64'd1 : in_tdata[133:70];
          off_r <= in_tdata[197:134];
          given_r <= in_tdata[261:198];
          if (in_tuser == sict_pkg::FUNC_INVALIDATE) valid_r <= '0;
        end
        sict_pkg::S_READ: was_valid_r <= valid_r[idx_r];
        sict_pkg::S_PREP: begin
          cur_r <= base;
          first_r <= base;
          off_pass_r <= off_r >= step_r;
          quo_r <= (off_r >= step_r) ? off_r : base;
          rem_r <= '0;
          bit_r <= 7'(W - 1);
          if (in_tab_r && (func_r == sict_pkg::FUNC_SEED || (func_r == sict_pkg::FUNC_NOTE
              && given_r != sict_pkg::ALL_ONES))) valid_r[idx_r] <= 1'b1;
          ostat_r <= sict_pkg::ST_NONE;
          ofirst_r <= '0;
          if (func_r == sict_pkg::FUNC_SEED || func_r == sict_pkg::FUNC_RESERVE) begin
            ostat_r <= sict_pkg::ST_ABSENT;
          end
          if (step_r <= 1) begin
            acc_r <= '0;
            mcand_r <= step_r;
            mplier_r <= cnt_r - 1'b1;
            ovf_r <= 1'b0;
          end
        end
        sict_pkg::S_DIV: begin
          if (!trial[W]) begin
            rem_r <= trial[W-1:0];
            quo_r <= {quo_r[W-2:0], 1'b1};
          end else begin
            rem_r <= {rem_r[W-2:0], quo_r[W-1]};
            quo_r <= {quo_r[W-2:0], 1'b0};
          end
          bit_r <= bit_r - 1'b1;
        end
        sict_pkg::S_ALIGN: begin
          if (off_pass_r) begin
            off_pass_r <= 1'b0;
            off_r <= rem_r;
            quo_r <= cur_r;
            rem_r <= '0;
            bit_r <= 7'(W - 1);
          end else begin
            if (offm == rem_r) first_r <= cur_r;
            else if (sum1[W]) first_r <= sict_pkg::ALL_ONES;
            else first_r <= sum1[W-1:0];
            acc_r <= '0;
            mcand_r <= step_r;
            mplier_r <= k;
            ovf_r <= 1'b0;
            bit_r <= 7'(W - 1);
          end
        end
        sict_pkg::S_MUL: begin
          if (mplier_r[0]) begin
            acc_r <= msum[W-1:0];
            if (msum[W]) ovf_r <= 1'b1;
          end
          if (mplier_r[W-1:1] != '0 && mcand_r[W-1]) ovf_r <= 1'b1;
          mcand_r <= {mcand_r[W-2:0], 1'b0};
          mplier_r <= {1'b0, mplier_r[W-1:1]};
          bit_r <= bit_r - 1'b1;
        end
        sict_pkg::S_WRITE: begin
          ostat_r <= sict_pkg::ST_ISSUED;
          ofirst_r <= first_r;
        end
        sict_pkg::S_OUT: obusy_r <= 1'b1;
        default: ;
      endcase
    end
  end

  `SICT_ASSERT_IMPL(a_busy_blocks_in, clk, rst_n, obusy_r, !in_tready)
  `SICT_ASSERT_NEXT(a_out_after_out, clk, rst_n, state_r == sict_pkg::S_OUT, out_tvalid)
  `SICT_ASSERT_IMPL(a_write_only_busy, clk, rst_n, we, state_r != sict_pkg::S_IDLE)
endmodule
